FILE: hdl/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg
// types, constants and controller codes shared by the shuffle pick core
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 256;

  localparam logic [63:0] MIX_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL1  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL2  = 64'h94D049BB133111EB;

  typedef struct packed {
    logic signed [31:0] day_serial;
    logic [11:0]        entry_count;
  } ssp_in_t;

  typedef struct packed {
    logic [7:0] picked_index;
    logic       count_error;
  } ssp_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_INIT,
    ST_MIX,
    ST_MOD,
    ST_RD,
    ST_WRI,
    ST_WRJ,
    ST_PICK,
    ST_PICKW,
    ST_DONE
  } ssp_state_t;

  typedef struct packed {
    logic load;      // capture item, set up division
    logic div_step;  // one restoring division step
    logic div_fix;   // floor correction and seeding
    logic init_wr;   // write identity entry
    logic mix_step;  // one mixer pipeline step
    logic mod_step;  // one modulo step
    logic rd;        // read entries i and j
    logic wr_i;      // store[i] <= old store[j]
    logic wr_j;      // store[j] <= old store[i]
    logic dec_i;
    logic pick_rd;
    logic done;
  } ssp_cmd_t;

  typedef struct packed {
    logic bad_count;
    logic small_count;
    logic div_last;
    logic init_last;
    logic mix_last;
    logic mod_last;
    logic shuf_last;
  } ssp_sts_t;

endpackage

FILE: hdl/seeded_shuffle_position_pick_core.sv
// ----------------------------------------------------------------------------
// seeded_shuffle_position_pick_core
// picks a shuffled list entry for a day number via seeded fisher-yates
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy low; the result shows on out_
// for one cycle with out_valid and cannot be stalled. For a count n in
// 2..MAX_ENTRIES the core runs a bit-serial division, n identity writes, then
// per shuffle step a mixer pass, a bit-serial modulo and a ram read and two
// writes, and finally a ram read for the pick. Counts below 2 or above
// MAX_ENTRIES skip all of these and go straight to done.
module seeded_shuffle_position_pick_core #(
  parameter int unsigned MAX_ENTRIES = ssp_pkg::MAX_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ssp_pkg::ssp_in_t  in_item,
  output logic              out_valid,
  output ssp_pkg::ssp_out_t out_item
);
  import ssp_pkg::*;

  ssp_cmd_t cmd;
  ssp_sts_t sts;
  ssp_out_t res;

  ssp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
  );

  ssp_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk(clk), .in_item(in_item), .cmd(cmd), .sts(sts), .result(res)
  );

  assign out_valid = cmd.done;
  assign out_item  = cmd.done ? res : '0;

endmodule

FILE: hdl/ssp_ram.sv
// ----------------------------------------------------------------------------
// ssp_ram
// generic single-port write, dual-port read ram with registered read
// ----------------------------------------------------------------------------
module ssp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: hdl/ssp_ctrl.sv
// ----------------------------------------------------------------------------
// ssp_ctrl
// sequencer for division, identity fill, shuffle steps and final pick
// ----------------------------------------------------------------------------
module ssp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ssp_pkg::ssp_sts_t sts,
  output ssp_pkg::ssp_cmd_t cmd,
  output logic              busy
);
  import ssp_pkg::*;

  ssp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.bad_count || sts.small_count) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.div_step = 1'b1;
          if (sts.div_last) state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init_wr = 1'b1;
        if (sts.init_last) begin
          cmd.div_fix = 1'b1;
          state_nxt   = ST_MIX;
        end
      end
      ST_MIX: begin
        cmd.mix_step = 1'b1;
        if (sts.mix_last) state_nxt = ST_MOD;
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) state_nxt = ST_RD;
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_WRI;
      end
      ST_WRI: begin
        cmd.wr_i  = 1'b1;
        state_nxt = ST_WRJ;
      end
      ST_WRJ: begin
        cmd.wr_j  = 1'b1;
        cmd.dec_i = 1'b1;
        state_nxt = sts.shuf_last ? ST_PICK : ST_MIX;
      end
      ST_PICK: begin
        cmd.pick_rd = 1'b1;
        state_nxt   = ST_PICKW;
      end
      ST_PICKW: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.done  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.done |=> state_r == ST_IDLE) else $error("done not followed by idle");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !busy) else $error("load while busy");
  a_wr_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_i |-> $past(cmd.rd)) else $error("write without read");

endmodule

FILE: hdl/ssp_dp.sv
// ----------------------------------------------------------------------------
// ssp_dp
// datapath: floor divider, splitmix64 mixer, modulo unit and permutation ram
// ----------------------------------------------------------------------------
module ssp_dp #(
  parameter int unsigned MAX_ENTRIES = ssp_pkg::MAX_ENTRIES_DEF
) (
  input  logic              clk,
  input  ssp_pkg::ssp_in_t  in_item,
  input  ssp_pkg::ssp_cmd_t cmd,
  output ssp_pkg::ssp_sts_t sts,
  output ssp_pkg::ssp_out_t result
);
  import ssp_pkg::*;

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned EW = $clog2(MAX_ENTRIES + 1);

  logic [11:0]        n_r;
  logic               neg_r;
  logic [31:0]        mag_r;     // dividend magnitude, shifted into quotient
  logic [12:0]        rem_r;     // division remainder
  logic [5:0]         dcnt_r;
  logic [AW-1:0]      pos_r;
  logic [EW-1:0]      i_r;
  logic [EW-1:0]      k_r;       // init counter
  logic [63:0]        st_r;
  logic [63:0]        z_r;
  logic [63:0]        p_r;       // partial product
  logic [2:0]         mcnt_r;
  logic [63:0]        mq_r;      // modulo dividend bits
  logic [EW:0]        mrem_r;
  logic [6:0]         mocnt_r;
  logic [AW-1:0]      j_r;
  logic [7:0]         out_idx_r;
  logic               err_r;
  logic               pick_d_r;

  // division: unsigned 32 / 12 restoring, one bit a cycle
  logic [12:0] rsh;
  logic [12:0] rsub;
  assign rsh  = {rem_r[11:0], mag_r[31]};
  assign rsub = rsh - {1'b0, n_r};

  // floor fix on magnitude quotient q and remainder r
  logic [31:0] q_u;
  logic [11:0] r_u;
  logic signed [32:0] cyc;
  logic [11:0] posv;
  always_comb begin
    q_u = mag_r;
    r_u = rem_r[11:0];
    if (!neg_r) begin
      cyc  = $signed({1'b0, q_u});
      posv = r_u;
    end else if (r_u == 12'd0) begin
      cyc  = -$signed({1'b0, q_u});
      posv = 12'd0;
    end else begin
      cyc  = -$signed({1'b0, q_u}) - 33'sd1;
      posv = n_r - r_u;
    end
  end

  // mixer: each 64-bit product built from three 32x32 pieces
  logic [63:0] mop_a;
  logic [63:0] mop_b;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [63:0] mix_in;
  always_comb begin
    if (mcnt_r < 3'd4) begin
      mop_a = z_r ^ (z_r >> 30);
      mop_b = MIX_MUL1;
    end else begin
      mop_a = z_r ^ (z_r >> 27);
      mop_b = MIX_MUL2;
    end
    case (mcnt_r)
      3'd2, 3'd5: begin
        mul_a = mop_a[31:0];
        mul_b = mop_b[63:32];
      end
      3'd3, 3'd6: begin
        mul_a = mop_a[63:32];
        mul_b = mop_b[31:0];
      end
      default: begin
        mul_a = mop_a[31:0];
        mul_b = mop_b[31:0];
      end
    endcase
    mul_p = 64'(mul_a) * 64'(mul_b);
    case (mcnt_r)
      3'd0:                   mix_in = st_r + MIX_GAMMA;
      3'd1, 3'd4:             mix_in = mul_p;
      3'd2, 3'd3, 3'd5, 3'd6: mix_in = p_r + {mul_p[31:0], 32'd0};
      default:                mix_in = z_r ^ (z_r >> 31);
    endcase
  end

  // modulo by i+1, one bit a cycle
  logic [EW:0] msh;
  logic [EW:0] msub;
  logic [EW:0] dv;
  assign dv   = {1'b0, i_r} + 1'b1;
  assign msh  = {mrem_r[EW-1:0], mq_r[63]};
  assign msub = msh - dv;

  // ram ports
  logic          we;
  logic [AW-1:0] waddr, ra, rb;
  logic [7:0]    wdata;
  logic [7:0]    rda, rdb;
  logic [7:0]    va_r;

  always_comb begin
    we    = cmd.init_wr | cmd.wr_i | cmd.wr_j;
    waddr = k_r[AW-1:0];
    wdata = k_r[7:0];
    if (cmd.wr_i) begin
      waddr = i_r[AW-1:0];
      wdata = rdb;
    end else if (cmd.wr_j) begin
      waddr = j_r;
      wdata = va_r;
    end
    ra = cmd.pick_rd ? pos_r : i_r[AW-1:0];
    rb = j_r;
  end

  ssp_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(ra), .raddr_b(rb), .rdata_a(rda), .rdata_b(rdb)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r    <= in_item.entry_count;
      neg_r  <= in_item.day_serial[31];
      mag_r  <= in_item.day_serial[31] ? (32'd0 - in_item.day_serial)
                                        : in_item.day_serial;
      rem_r  <= '0;
      dcnt_r <= '0;
      k_r    <= '0;
      out_idx_r <= '0;
      err_r  <= ({1'b0, in_item.entry_count} > 13'(MAX_ENTRIES));
    end
    if (cmd.div_step) begin
      mag_r  <= {mag_r[30:0], ~rsub[12]};
      rem_r  <= rsub[12] ? rsh : rsub;
      dcnt_r <= dcnt_r + 6'd1;
    end
    if (cmd.init_wr) k_r <= k_r + 1'b1;
    if (cmd.div_fix) begin
      st_r   <= {{31{cyc[32]}}, cyc} ^ {20'd0, n_r, 32'd0};
      pos_r  <= posv[AW-1:0];
      i_r    <= EW'(n_r - 12'd1);
      mcnt_r <= '0;
    end
    if (cmd.mix_step) begin
      case (mcnt_r)
        3'd0: begin
          st_r <= mix_in;
          z_r  <= mix_in;
        end
        3'd3, 3'd6: z_r <= mix_in;
        3'd7: mq_r <= mix_in;
        default: p_r <= mix_in;
      endcase
      mcnt_r  <= mcnt_r + 3'd1;
      mrem_r  <= '0;
      mocnt_r <= '0;
    end
    if (cmd.mod_step) begin
      mq_r    <= {mq_r[62:0], 1'b0};
      mrem_r  <= msub[EW] ? msh : msub;
      mocnt_r <= mocnt_r + 7'd1;
      if (mocnt_r == 7'd63) j_r <= msub[EW] ? msh[AW-1:0] : msub[AW-1:0];
    end
    if (cmd.wr_i) va_r <= rda;
    if (cmd.dec_i) i_r <= i_r - 1'b1;
    // ram data for the pick lands in the cycle after the read
    pick_d_r <= cmd.pick_rd;
    if (pick_d_r) out_idx_r <= rda;
  end

  always_comb begin
    sts.bad_count   = err_r;
    sts.small_count = (n_r < 12'd2);
    sts.div_last    = (dcnt_r == 6'd31);
    sts.init_last   = (k_r == EW'(n_r - 12'd1));
    sts.mix_last    = (mcnt_r == 3'd7);
    sts.mod_last    = (mocnt_r == 7'd63);
    sts.shuf_last   = (i_r == EW'(1));
    result.picked_index = out_idx_r;
    result.count_error  = err_r;
  end

endmodule

FILE: test/tb_seeded_shuffle_position_pick_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seeded_shuffle_position_pick_core
// self-checking bench for the seeded shuffle position pick core
// ----------------------------------------------------------------------------
// A short table of directed items covers the count extremes, error counts,
// small counts and the day number extremes. Random items follow, mostly with
// small counts so the shuffle stays short. Typed rows carry fixed expected
// results; the rest are checked against a behavioral shuffle-and-pick model held in this bench.
module tb_seeded_shuffle_position_pick_core;
  import ssp_pkg::*;

  localparam int unsigned MAX_N      = MAX_ENTRIES_DEF;
  localparam int          N_RANDOM   = 125;
  localparam int          IDLE_LIMIT = 80000;

  typedef struct packed {
    logic     typed;
    ssp_in_t  stim;
    ssp_out_t pick;
  } pick_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  ssp_in_t   in_item;
  logic      out_valid;
  ssp_out_t  out_item;

  ssp_out_t  pending_picks[$];
  pick_row_t rows[$];
  int        mismatches;
  int        results_seen;
  int        items_sent;
  int        idle_cycles;

  seeded_shuffle_position_pick_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // one splitmix64 step on a running state
  function automatic logic [63:0] splitmix(ref logic [63:0] mix);
    logic [63:0] z;
    mix = mix + MIX_GAMMA;
    z = mix;
    z = (z ^ (z >> 30)) * MIX_MUL1;
    z = (z ^ (z >> 27)) * MIX_MUL2;
    return z ^ (z >> 31);
  endfunction

  function automatic ssp_out_t shuffle_pick(ssp_in_t x);
    ssp_out_t    r;
    longint      day;
    longint      n;
    longint      cyc;
    longint      pos;
    logic [63:0] mix;
    logic [63:0] j;
    int unsigned perm[MAX_N];
    int unsigned t;
    r = '0;
    n = longint'(x.entry_count);
    if (n > MAX_N) begin
      r.count_error = 1'b1;
      return r;
    end
    if (n < 2) return r;
    day = longint'(x.day_serial);
    cyc = day / n;
    pos = day % n;
    if (pos < 0) begin
      pos += n;
      cyc -= 1;
    end
    for (int i = 0; i < n; i++) perm[i] = i;
    mix = 64'(cyc) ^ (64'(n) << 32);
    for (int i = int'(n) - 1; i > 0; i--) begin
      j = splitmix(mix) % 64'(i + 1);
      t = perm[i];
      perm[i] = perm[int'(j)];
      perm[int'(j)] = t;
    end
    r.picked_index = perm[int'(pos)][7:0];
    return r;
  endfunction

  function automatic void add_row(logic typed, logic [31:0] day, logic [11:0] n,
                                  logic [7:0] idx, logic err);
    pick_row_t r;
    r.typed = typed;
    r.stim.day_serial = day;
    r.stim.entry_count = n;
    r.pick.picked_index = idx;
    r.pick.count_error = err;
    rows.push_back(r);
  endfunction

  function automatic ssp_in_t random_item();
    ssp_in_t     x;
    int unsigned sel;
    x.day_serial = $urandom();
    sel = $urandom_range(99);
    if (sel < 8) x.entry_count = 12'($urandom_range(1));
    else if (sel < 18) x.entry_count = 12'($urandom_range(4095, MAX_N + 1));
    else if (sel < 24) x.entry_count = 12'($urandom_range(MAX_N, 17));
    else x.entry_count = 12'($urandom_range(16, 2));
    if ($urandom_range(9) == 0) x.day_serial = $urandom_range(20) - 10;
    return x;
  endfunction

  // result checker
  always @(posedge clk) begin
    ssp_out_t want;
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (pending_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result idx=%0d err=%0b", out_item.picked_index,
                   out_item.count_error);
      end else begin
        want = pending_picks.pop_front();
        if (out_item.picked_index !== want.picked_index ||
            out_item.count_error !== want.count_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected idx=%0d err=%0b, got idx=%0d err=%0b",
                     want.picked_index, want.count_error,
                     out_item.picked_index, out_item.count_error);
        end
      end
    end
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_picks.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    ssp_in_t     x;
    int          gap;
    int          burst;
    int          total;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;

    // directed table: typed rows are trivial cases, the rest use the model
    add_row(1, 32'd0,          12'd0,    8'd0, 1'b0);
    add_row(1, 32'hFFFFFFFF,   12'd1,    8'd0, 1'b0);
    add_row(1, 32'h7FFFFFFF,   12'd0,    8'd0, 1'b0);
    add_row(1, 32'h80000000,   12'd4095, 8'd0, 1'b1);
    add_row(1, 32'd5,          12'd257,  8'd0, 1'b1);
    add_row(1, 32'h80000000,   12'd1,    8'd0, 1'b0);
    add_row(0, 32'd0,          12'd2,    8'd0, 1'b0);
    add_row(0, 32'hFFFFFFFF,   12'd2,    8'd0, 1'b0);
    add_row(0, 32'h80000000,   12'd2,    8'd0, 1'b0);
    add_row(0, 32'h7FFFFFFF,   12'd2,    8'd0, 1'b0);
    add_row(0, 32'hFFFFFFF9,   12'd3,    8'd0, 1'b0);
    add_row(0, 32'd100,        12'd7,    8'd0, 1'b0);
    add_row(0, 32'hFFFFFFFF,   12'd16,   8'd0, 1'b0);
    add_row(0, 32'd0,          12'd256,  8'd0, 1'b0);
    add_row(0, 32'h80000000,   12'd256,  8'd0, 1'b0);
    add_row(0, 32'h7FFFFFFF,   12'd255,  8'd0, 1'b0);
    for (int i = 0; i < N_RANDOM; i++) begin
      x = random_item();
      add_row(0, x.day_serial, x.entry_count, 8'd0, 1'b0);
    end
    total = rows.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    burst = 0;
    foreach (rows[k]) begin
      start <= 1'b1;
      in_item <= rows[k].stim;
      do @(posedge clk); while (busy);
      pending_picks.push_back(rows[k].typed ? rows[k].pick : shuffle_pick(rows[k].stim));
      items_sent++;
      if (k == total - 1) break;
      // drain once midway through the random part
      if (k == total / 2) begin
        start <= 1'b0;
        wait (pending_picks.size() == 0);
        @(posedge clk);
        continue;
      end
      if (burst == 0) begin
        burst = $urandom_range(8, 1);
        gap = $urandom_range(3) == 0 ? 0 : $urandom_range(6, 1);
      end else begin
        gap = 0;
      end
      burst--;
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b0;

    wait (pending_picks.size() == 0);
    repeat (20) @(posedge clk);
    mismatches += pending_picks.size();
    $display("sent %0d items (%0d directed, %0d random), checked %0d results",
             items_sent, total - N_RANDOM, N_RANDOM, results_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/ssp_pkg.sv
hdl/ssp_ram.sv
hdl/ssp_ctrl.sv
hdl/ssp_dp.sv
hdl/seeded_shuffle_position_pick_core.sv
test/tb_seeded_shuffle_position_pick_core.sv
